@@ hw/rtl/fnv1a_stream_hasher_defines.svh @@
// ----------------------------------------------------------------------------
// FNV-1a stream hasher assertion macros
// Shared concurrent assertion forms for the hasher RTL.
// ----------------------------------------------------------------------------
`ifndef FNV1A_STREAM_HASHER_DEFINES_SVH
`define FNV1A_STREAM_HASHER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define FNV1A_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define FNV1A_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/fnv1a_pkg.sv @@
// ----------------------------------------------------------------------------
// FNV-1a hasher package
// Constants, register indexes and arithmetic helpers of the stream hasher.
// ----------------------------------------------------------------------------
package fnv1a_pkg;

  localparam int unsigned HASH_W  = 64;
  localparam int unsigned HALF_W  = 32;
  localparam int unsigned FOLD_W  = 7;
  localparam int unsigned INDEX_W = 8;

  localparam logic [HASH_W-1:0] PRIME64    = 64'd1099511628211;
  localparam logic [HALF_W-1:0] PRIME32    = 32'd16777619;
  localparam logic [HASH_W-1:0] SEED_RESET = 64'd14695981039346656037;
  localparam logic [FOLD_W-1:0] FOLD_RESET = 7'd64;

  // Register indexes of the configuration port
  localparam logic [INDEX_W-1:0] CFG_WIDE_MODE   = 8'd0;
  localparam logic [INDEX_W-1:0] CFG_SEED_VALUE  = 8'd1;
  localparam logic [INDEX_W-1:0] CFG_STRING_MODE = 8'd2;
  localparam logic [INDEX_W-1:0] CFG_FOLD_BITS   = 8'd3;

  // Multiply by the 64-bit prime 2^40 + 0x1B3 as a sum of shifts
  function automatic logic [HASH_W-1:0] mul_prime64(input logic [HASH_W-1:0] h);
    mul_prime64 = h + (h << 1) + (h << 4) + (h << 5) + (h << 7) + (h << 8)
                + (h << 40);
  endfunction

  // Multiply by the 32-bit prime 2^24 + 0x193 as a sum of shifts
  function automatic logic [HALF_W-1:0] mul_prime32(input logic [HALF_W-1:0] h);
    mul_prime32 = h + (h << 1) + (h << 4) + (h << 7) + (h << 8) + (h << 24);
  endfunction

  // Xor-fold down to the fold width; the greedy halving steps follow the bits
  // of (width - fold), so each bit selects one xor-shift
  function automatic logic [HASH_W-1:0] fold_hash(input logic [HASH_W-1:0] h,
                                                  input logic              wide,
                                                  input logic [FOLD_W-1:0] fold);
    logic [FOLD_W-1:0] width;
    logic [FOLD_W-1:0] fold_eff;
    logic [FOLD_W-1:0] rest;
    logic [HASH_W-1:0] acc;
    logic [HASH_W-1:0] mask;
    width    = wide ? 7'd64 : 7'd32;
    fold_eff = (fold > width) ? width : fold;
    rest     = width - fold_eff;
    acc      = h;
    for (int k = 5; k >= 0; k--) begin
      if (rest[k]) begin
        acc = acc ^ (acc >> (1 << k));
      end
    end
    // A shift by the full width clears the vector, giving an all-ones mask
    mask = ~({HASH_W{1'b1}} << fold_eff);
    fold_hash = acc & mask;
  endfunction

endpackage

@@ hw/rtl/fnv1a_stream_hasher.sv @@
// ----------------------------------------------------------------------------
// FNV-1a stream hasher
// Hashes a byte stream with FNV-1a (32 or 64 bit) and emits an xor-folded hash.
// ----------------------------------------------------------------------------
// The hasher takes one byte per clock cycle while s_tready is high; s_tready
// drops while a last byte waits on a full finished-hash register. That rate
// is set by the running-hash loop: xor with the byte and a shift-add multiply
// by the sparse FNV prime close combinationally. A last byte passes the input
// register, a finished-hash register and a result register, which returns the
// folded hash and lets new bytes flow in while it waits on m_tready. No
// clearing pass follows reset. The user must write configuration over the cfg
// port only while the stream is idle; the block itself does not enforce this.
module fnv1a_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  // input byte stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] first_byte
  input  logic        s_tlast,   // last_byte
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [63:0] hash_value
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  `include "fnv1a_stream_hasher_defines.svh"

  // configuration registers
  logic        wide_mode;
  logic [63:0] seed_value;
  logic        string_mode;
  logic [6:0]  fold_bits;

  // input stage
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_first;
  logic       in_last;

  // hash state
  logic [63:0] running_hash;
  logic        terminated;
  logic [63:0] running_hash_next;
  logic        terminated_next;

  // finished hash waiting for the fold
  logic        fin_valid;
  logic [63:0] fin_hash;
  logic        fin_wide;

  // result stage
  logic        out_valid;
  logic [63:0] out_data;

  logic        out_free;
  logic        fin_free;
  logic        in_go;
  logic        in_free;

  logic [63:0] base_hash;
  logic        base_term;
  logic        stop_byte;
  logic        hash_en;
  logic [31:0] hash32;

  // Advance each stage when the one after it has room
  assign out_free = !out_valid || m_tready;
  assign fin_free = !fin_valid || out_free;
  assign in_go    = in_valid && (!in_last || fin_free);
  assign in_free  = !in_valid || in_go;

  assign s_tready  = in_free;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      wide_mode   <= 1'b1;
      seed_value  <= fnv1a_pkg::SEED_RESET;
      string_mode <= 1'b0;
      fold_bits   <= fnv1a_pkg::FOLD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        fnv1a_pkg::CFG_WIDE_MODE:   wide_mode   <= cfg_data[0];
        fnv1a_pkg::CFG_SEED_VALUE:  seed_value  <= cfg_data;
        fnv1a_pkg::CFG_STRING_MODE: string_mode <= cfg_data[0];
        fnv1a_pkg::CFG_FOLD_BITS:   fold_bits   <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  // Apply one byte to the running hash
  always_comb begin
    if (in_first) begin
      base_hash = wide_mode ? seed_value : {32'd0, seed_value[31:0]};
      base_term = 1'b0;
    end else begin
      base_hash = running_hash;
      base_term = terminated;
    end
    stop_byte = string_mode && !base_term && (in_byte == 8'd0);
    hash_en   = !stop_byte && (!string_mode || !base_term);
    hash32    = fnv1a_pkg::mul_prime32(base_hash[31:0] ^ {24'd0, in_byte});
    terminated_next = base_term || stop_byte;
    if (!hash_en) begin
      running_hash_next = base_hash;
    end else if (wide_mode) begin
      running_hash_next = fnv1a_pkg::mul_prime64(base_hash ^ {56'd0, in_byte});
    end else begin
      running_hash_next = {32'd0, hash32};
    end
  end

  // Hold control state of every stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      fin_valid    <= 1'b0;
      out_valid    <= 1'b0;
      running_hash <= '0;
      terminated   <= 1'b0;
    end else begin
      if (in_free) begin
        in_valid <= s_tvalid;
      end
      if (in_go) begin
        running_hash <= running_hash_next;
        terminated   <= terminated_next;
      end
      if (in_go && in_last) begin
        fin_valid <= 1'b1;
      end else if (out_free) begin
        fin_valid <= 1'b0;
      end
      if (out_free) begin
        out_valid <= fin_valid;
      end
    end
  end

  // Move payload along with its stage
  always_ff @(posedge clk) begin
    if (in_free) begin
      in_byte  <= s_tdata;
      in_first <= s_tuser;
      in_last  <= s_tlast;
    end
    if (in_go && in_last) begin
      fin_hash <= wide_mode ? running_hash_next : {32'd0, running_hash_next[31:0]};
      fin_wide <= wide_mode;
    end
    if (out_free && fin_valid) begin
      out_data <= fnv1a_pkg::fold_hash(fin_hash, fin_wide, fold_bits);
    end
  end

  // A last byte always leaves a finished hash behind
  `FNV1A_ASSERT_NEXT(a_last_loads_fin, clk, rst, in_go && in_last, fin_valid, "last byte lost")

  // 32-bit updates keep the upper half of the hash clear
  `FNV1A_ASSERT_NEXT(a_narrow_upper_zero, clk, rst, in_go && hash_en && !wide_mode, running_hash[63:32] == 32'd0, "upper hash bits set")

  // The shift-add product matches a true multiply by the prime
  `FNV1A_ASSERT_NEXT(a_mul64, clk, rst, in_go && hash_en && wide_mode, running_hash == $past((base_hash ^ {56'd0, in_byte}) * fnv1a_pkg::PRIME64), "64-bit prime product wrong")

  // A finished hash blocked by the result stage holds still
  `FNV1A_ASSERT_NEXT(a_fin_hold, clk, rst, fin_valid && !out_free, fin_valid && $stable(fin_hash), "finished hash dropped while blocked")

endmodule
